@@ hdl/region_window_address_translator_macros.svh @@
// Assertion macros shared by the address window translator RTL.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef REGION_WINDOW_ADDRESS_TRANSLATOR_MACROS_SVH
`define REGION_WINDOW_ADDRESS_TRANSLATOR_MACROS_SVH

// Same-cycle implication, masked during reset
`define RWAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset
`define RWAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rwat_pkg.sv @@
// Package for the address window translator: sizes, codes and the token
// that walks the cell row. No dependencies.
package rwat_pkg;

  // Table depth, 1..64
  localparam int ENTRIES = 20;

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int TBASE_W = 48;
  localparam int SPAN_W  = 31;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = SLOT_W + 1;

  typedef enum logic {
    MODE_ADD   = 1'b0,
    MODE_XLATE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOMATCH = 2'd2
  } status_t;

  // Request token handed from cell to cell
  typedef struct packed {
    logic               valid;
    mode_t              mode;
    logic               done;
    logic [ADDR_W-1:0]  dev_addr;
    logic [TBASE_W-1:0] target_base;
    logic [SPAN_W-1:0]  span;
    logic [TBASE_W-1:0] target_addr;
    logic [SLOT_W-1:0]  hit_slot;
  } tok_t;

endpackage

@@ hdl/rwat_ifs.sv @@
// Valid/ready channel interfaces for the address window translator.
// Depends on rwat_pkg for field widths.
interface rwat_in_if import rwat_pkg::*;;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [ADDR_W-1:0]  dev_addr;
  logic [TBASE_W-1:0] target_base;
  logic [SPAN_W-1:0]  span;

  modport source (output valid, mode, dev_addr, target_base, span, input ready);
  modport sink   (input valid, mode, dev_addr, target_base, span, output ready);
endinterface

interface rwat_out_if import rwat_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [TBASE_W-1:0] target_addr;
  logic [SLOT_W-1:0]  hit_slot;

  modport source (output valid, status, target_addr, hit_slot, input ready);
  modport sink   (input valid, status, target_addr, hit_slot, output ready);
endinterface

@@ hdl/rwat_cell.sv @@
// One window cell: holds a single address window and checks the passing token.
// Depends on rwat_pkg.
module rwat_cell import rwat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [SLOT_W-1:0] slot_idx,
  input  logic [CNT_W-1:0]  win_count,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  logic [ADDR_W-1:0]  base_r;
  logic [TBASE_W-1:0] tbase_r;
  logic [SPAN_W-1:0]  len_r;

  logic               valid_r;
  tok_t               tok_r;
  tok_t               tok_nxt;

  logic               occupied;
  logic               addr_ge;
  logic               lim_ok;
  logic [ADDR_W:0]    acc_end;
  logic [ADDR_W:0]    win_end;
  logic [TBASE_W-1:0] xlat;
  logic               add_here;
  logic               hit_here;

  // Window match: base <= addr and addr + span <= base + len (33-bit, no wrap)
  always_comb begin
    occupied = {1'b0, slot_idx} < win_count;
    addr_ge  = tok_i.dev_addr >= base_r;
    acc_end  = {1'b0, tok_i.dev_addr} + {{(ADDR_W+1-SPAN_W){1'b0}}, tok_i.span};
    win_end  = {1'b0, base_r} + {{(ADDR_W+1-SPAN_W){1'b0}}, len_r};
    lim_ok   = acc_end <= win_end;
    xlat     = tbase_r + {{(TBASE_W-ADDR_W){1'b0}}, tok_i.dev_addr}
                       - {{(TBASE_W-ADDR_W){1'b0}}, base_r};
  end

  // Claim the token: append on the first free slot, or translate on a hit
  always_comb begin
    add_here = tok_i.valid && !tok_i.done && (tok_i.mode == MODE_ADD)
               && ({1'b0, slot_idx} == win_count);
    hit_here = tok_i.valid && !tok_i.done && (tok_i.mode == MODE_XLATE)
               && occupied && addr_ge && lim_ok;
    tok_nxt  = tok_i;
    if (add_here) begin
      tok_nxt.done        = 1'b1;
      tok_nxt.hit_slot    = slot_idx;
      tok_nxt.target_addr = '0;
    end else if (hit_here) begin
      tok_nxt.done        = 1'b1;
      tok_nxt.hit_slot    = slot_idx;
      tok_nxt.target_addr = xlat;
    end
  end

  // Window storage, written once by an add
  always_ff @(posedge clk) begin
    if (adv && add_here) begin
      base_r  <= tok_i.dev_addr;
      tbase_r <= tok_i.target_base;
      len_r   <= tok_i.span;
    end
  end

  // Token stage toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= tok_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  always_comb begin
    tok_o       = tok_r;
    tok_o.valid = valid_r;
  end

endmodule

@@ hdl/region_window_address_translator.sv @@
// An accepted input beat passes the token register of each window cell, then the output
// register, which raises out valid. One item at a time: no new beat is taken until the
// last token leaves the row; a token moves one cell per cycle unless the row stalls.
// A waiting result sits in the output register; the row stalls only when it is full.
// Reset (synchronous, rst_n low) empties the table and drops any item in flight.
module region_window_address_translator import rwat_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rwat_in_if.sink    in_ch,
  rwat_out_if.source out_ch
);

  tok_t               chain [ENTRIES+1];
  tok_t               tail;
  logic [ENTRIES-1:0] tok_vld;

  logic               busy_r;
  logic               busy_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  logic               out_valid_r;
  logic               out_valid_nxt;
  status_t            out_status_r;
  logic [TBASE_W-1:0] out_addr_r;
  logic [SLOT_W-1:0]  out_slot_r;
  status_t            tail_status;

  logic               in_acc;
  logic               adv;
  logic               cap;
  logic               add_ok;

  // Handshake and row advance
  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign tail        = chain[ENTRIES];
  assign adv         = !(tail.valid && out_valid_r && !out_ch.ready);
  assign cap         = tail.valid && adv;
  assign add_ok      = cap && (tail.mode == MODE_ADD) && tail.done;

  // Fresh token entering the first cell
  always_comb begin
    chain[0].valid       = in_acc;
    chain[0].mode        = mode_t'(in_ch.mode);
    chain[0].done        = 1'b0;
    chain[0].dev_addr    = in_ch.dev_addr;
    chain[0].target_base = in_ch.target_base;
    chain[0].span        = in_ch.span;
    chain[0].target_addr = '0;
    chain[0].hit_slot    = '0;
  end

  // Row of window cells, lowest slot first
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    rwat_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .slot_idx  (SLOT_W'(g)),
      .win_count (count_r),
      .tok_i     (chain[g]),
      .tok_o     (chain[g+1])
    );
    assign tok_vld[g] = chain[g+1].valid;
  end

  // Tail status: OK when the token was claimed, else depends on its mode
  always_comb begin
    if (tail.done) begin
      tail_status = STAT_OK;
    end else if (tail.mode == MODE_ADD) begin
      tail_status = STAT_FULL;
    end else begin
      tail_status = STAT_NOMATCH;
    end
  end

  // Control next state
  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (cap) begin
      busy_nxt = 1'b0;
    end
    count_nxt = count_r;
    if (add_ok) begin
      count_nxt = count_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (cap) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cap) begin
      out_status_r <= tail_status;
      out_addr_r   <= tail.target_addr;
      out_slot_r   <= tail.hit_slot;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.target_addr = out_addr_r;
  assign out_ch.hit_slot    = out_slot_r;

  // Checks
  `include "region_window_address_translator_macros.svh"

  `RWAT_ASSERT_IMP(a_accept_row_empty, in_acc, tok_vld == '0, "beat accepted with token in row")
  `RWAT_ASSERT_NXT(a_accept_busy, in_acc, busy_r, "busy not set after accept")
  `RWAT_ASSERT_IMP(a_idle_row_empty, !busy_r, tok_vld == '0, "token in row while idle")
  `RWAT_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(ENTRIES), "window count overrun")
  `RWAT_ASSERT_NXT(a_add_counts, add_ok, count_r == $past(count_r) + 1'b1, "add not counted")

endmodule
